>>> design/assoc_position_cache_replace_defines.svh
// Assertion macros used by the position cache design.
`ifndef ASSOC_POSITION_CACHE_REPLACE_DEFINES_SVH
`define ASSOC_POSITION_CACHE_REPLACE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define APCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("position cache assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define APCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("position cache assertion failed");

`endif

>>> design/apcr_pkg.sv
// Types and constants of the associative position cache.
`timescale 1ns / 1ps

package apcr_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SQUARES   = 64;
  localparam int KEY_WORDS = SQUARES / 8;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int FILL_W    = $clog2(MAX_SLOTS + 1);
  localparam int KEY_ROW_W = 64 * KEY_WORDS + 1;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 9;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] OUT_FOUND     = 3'd0;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd1;
  localparam logic [2:0] OUT_ADDED     = 3'd2;
  localparam logic [2:0] OUT_REPLACED  = 3'd3;
  localparam logic [2:0] OUT_REFUSED   = 3'd4;
  localparam logic [2:0] OUT_CLEARED   = 3'd5;

  localparam logic CFG_REPLACE_POLICY = 1'b0;
  localparam logic CFG_CAPACITY       = 1'b1;

  localparam logic POLICY_OLDEST   = 1'b0;
  localparam logic POLICY_SMALLEST = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_word_0;
    logic [63:0] key_word_1;
    logic [63:0] key_word_2;
    logic [63:0] key_word_3;
    logic [63:0] key_word_4;
    logic [63:0] key_word_5;
    logic [63:0] key_word_6;
    logic [63:0] key_word_7;
    logic        side_to_move;
    logic [31:0] total_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [7:0] slot;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MOD,
    ST_MINSCAN
  } apcr_state_t;

endpackage

>>> design/assoc_position_cache_replace.sv
// Fully associative position cache with oldest or smallest-count replacement.
// Lookup or add searches the filled slots, one slot per cycle.
// A smallest-count replacement then rescans the counts for the new minimum; an oldest
// replacement reduces the round-robin wrap by repeated subtraction of the capacity.
// One item at a time: busy is high until the result, and the next item may start then.
// Synchronous active-low reset empties the cache; slot memories need no clearing.
`timescale 1ns / 1ps

module assoc_position_cache_replace
  import apcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "assoc_position_cache_replace_defines.svh"

  logic [KEY_ROW_W-1:0] key_mem [MAX_SLOTS];
  logic [COUNT_W-1:0]   cnt_mem [MAX_SLOTS];
  logic [KEY_ROW_W-1:0] key_rd_q;
  logic [COUNT_W-1:0]   cnt_rd_q;

  apcr_state_t          state_r, state_nxt;
  in_item_t             item_r, item_nxt;
  logic [FILL_W-1:0]    idx_r, idx_nxt;
  logic                 pv_r, pv_nxt;
  logic [SLOT_W-1:0]    pidx_r, pidx_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]    recent_r, recent_nxt;
  logic [COUNT_W-1:0]   low_cnt_r, low_cnt_nxt;
  logic [SLOT_W-1:0]    low_slot_r, low_slot_nxt;
  logic                 policy_r;
  logic [FILL_W-1:0]    cap_r;
  logic [FILL_W-1:0]    rem_r, rem_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [SLOT_W-1:0]    rd_addr;
  logic [FILL_W-1:0]    cap_eff;
  logic [KEY_ROW_W-1:0] item_row;
  logic                 accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign rd_addr   = idx_r[SLOT_W-1:0];

  assign item_row = {item_r.side_to_move, item_r.key_word_7, item_r.key_word_6,
                     item_r.key_word_5, item_r.key_word_4, item_r.key_word_3,
                     item_r.key_word_2, item_r.key_word_1, item_r.key_word_0};

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = FILL_W'(1);
    end else if (cap_r > FILL_W'(MAX_SLOTS)) begin
      cap_eff = FILL_W'(MAX_SLOTS);
    end else begin
      cap_eff = cap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= item_row;
      cnt_mem[mem_waddr] <= item_r.total_count;
    end
    key_rd_q <= key_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_OLDEST;
      cap_r    <= FILL_W'(MAX_SLOTS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE_POLICY: policy_r <= cfg_data[0];
        CFG_CAPACITY:       cap_r    <= cfg_data[FILL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      fill_r      <= '0;
      recent_r    <= '0;
      low_cnt_r   <= '0;
      low_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      fill_r      <= fill_nxt;
      recent_r    <= recent_nxt;
      low_cnt_r   <= low_cnt_nxt;
      low_slot_r  <= low_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    rem_r      <= rem_nxt;
    res_slot_r <= res_slot_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    fill_nxt      = fill_r;
    recent_nxt    = recent_r;
    low_cnt_nxt   = low_cnt_r;
    low_slot_nxt  = low_slot_r;
    rem_nxt       = rem_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[SLOT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_CLEAR) begin
            fill_nxt      = '0;
            recent_nxt    = '0;
            out_valid_nxt = 1'b1;
            out_nxt       = '{outcome: OUT_CLEARED, slot: 8'd0};
          end else begin
            item_nxt  = in_item;
            idx_nxt   = '0;
            pv_nxt    = 1'b0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        priority if (pv_r && (key_rd_q == item_row)) begin
          if (item_r.mode == MODE_ADD) begin
            recent_nxt = pidx_r;
          end
          out_valid_nxt = 1'b1;
          out_nxt       = '{outcome: OUT_FOUND, slot: 8'(pidx_r)};
          pv_nxt        = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (idx_r < fill_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt  = idx_r + FILL_W'(1);
        end else begin
          pv_nxt    = 1'b0;
          state_nxt = ST_IDLE;
          if (item_r.mode != MODE_ADD) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{outcome: OUT_NOT_FOUND, slot: 8'd0};
          end else if (fill_r < cap_eff) begin
            mem_we    = 1'b1;
            mem_waddr = fill_r[SLOT_W-1:0];
            if ((fill_r == '0) || (item_r.total_count < low_cnt_r)) begin
              low_cnt_nxt  = item_r.total_count;
              low_slot_nxt = fill_r[SLOT_W-1:0];
            end
            fill_nxt      = fill_r + FILL_W'(1);
            out_valid_nxt = 1'b1;
            out_nxt       = '{outcome: OUT_ADDED, slot: 8'(fill_r[SLOT_W-1:0])};
          end else if (policy_r == POLICY_SMALLEST) begin
            if (item_r.total_count < low_cnt_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{outcome: OUT_REFUSED, slot: 8'd0};
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = low_slot_r;
              res_slot_nxt = low_slot_r;
              low_cnt_nxt  = item_r.total_count;
              idx_nxt      = '0;
              state_nxt    = ST_MINSCAN;
            end
          end else begin
            rem_nxt   = {1'b0, recent_r} + FILL_W'(1);
            state_nxt = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (rem_r >= cap_eff) begin
          rem_nxt = rem_r - cap_eff;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = rem_r[SLOT_W-1:0];
          recent_nxt    = rem_r[SLOT_W-1:0];
          out_valid_nxt = 1'b1;
          out_nxt       = '{outcome: OUT_REPLACED, slot: 8'(rem_r[SLOT_W-1:0])};
          state_nxt     = ST_IDLE;
        end
      end

      ST_MINSCAN: begin
        if (pv_r && (cnt_rd_q < low_cnt_r)) begin
          low_cnt_nxt  = cnt_rd_q;
          low_slot_nxt = pidx_r;
        end
        if (idx_r < fill_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt  = idx_r + FILL_W'(1);
        end else begin
          pv_nxt        = 1'b0;
          out_valid_nxt = 1'b1;
          out_nxt       = '{outcome: OUT_REPLACED, slot: 8'(res_slot_r)};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `APCR_ASSERT_NOW(a_fill_bounded, 1'b1, fill_r <= FILL_W'(MAX_SLOTS))
  `APCR_ASSERT_NOW(a_result_when_idle, out_valid_r, state_r == ST_IDLE)
  `APCR_ASSERT_NEXT(a_accept_progress, accept, out_valid_r || busy)
  `APCR_ASSERT_NOW(a_pending_in_fill, (state_r == ST_SEARCH) && pv_r,
                   {1'b0, pidx_r} < fill_r)

endmodule

>>> dv/testbench.sv
// Testbench of the associative position cache: random and directed items against a predictor.
`timescale 1ns / 1ps

module testbench;
  import apcr_pkg::*;

  localparam logic [1:0] MODE_LOOKUP_ALT = 2'd3;
  localparam int POOL_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int END_WAIT    = 5000;
  localparam int SETTLE      = 1000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_item_t                 in_item;
  logic                     out_valid;
  out_item_t                out_item;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Predicted cache contents and control registers.
  logic [KEY_ROW_W-1:0]     row_mem [MAX_SLOTS];
  logic [COUNT_W-1:0]       count_mem [MAX_SLOTS];
  int                       filled = 0;
  int                       newest = 0;
  logic [COUNT_W-1:0]       min_count = '0;
  int                       min_slot = 0;
  logic                     policy_sel = POLICY_OLDEST;
  logic [CFG_W-1:0]         cap_setting = 9'd256;

  out_item_t                due_results [$];
  out_item_t                want;
  in_item_t                 key_pool [POOL_DEPTH];
  int                       pool_size = 4;
  bit                       steady_sender = 1'b0;
  int                       mismatch_count = 0;
  int                       items_sent = 0;
  int                       results_checked = 0;
  int                       settings_used = 1;
  int                       outcome_seen [6] = '{default: 0};
  int                       cycles_run = 0;

  assoc_position_cache_replace i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic out_item_t model_cache_access(input in_item_t it);
    out_item_t            res;
    logic [KEY_ROW_W-1:0] row;
    int                   hit;
    int                   cap;
    int                   s;
    int                   i;
    row = it[KEY_ROW_W+COUNT_W-1:COUNT_W];
    cap = (cap_setting == 0) ? 1 : (cap_setting > MAX_SLOTS) ? MAX_SLOTS : int'(cap_setting);
    res.slot = '0;
    hit = -1;
    for (i = 0; i < filled && hit < 0; i++) begin
      if (row_mem[i] == row) hit = i;
    end
    if (it.mode == MODE_CLEAR) begin
      filled = 0;
      newest = 0;
      res.outcome = OUT_CLEARED;
    end else if (it.mode != MODE_ADD) begin
      res.outcome = (hit >= 0) ? OUT_FOUND : OUT_NOT_FOUND;
      if (hit >= 0) res.slot = hit[7:0];
    end else if (hit >= 0) begin
      newest = hit;
      res.outcome = OUT_FOUND;
      res.slot = hit[7:0];
    end else if (filled >= cap) begin
      if (policy_sel == POLICY_SMALLEST) begin
        if (it.total_count < min_count) begin
          res.outcome = OUT_REFUSED;
        end else begin
          s = min_slot % MAX_SLOTS;
          row_mem[s] = row;
          count_mem[s] = it.total_count;
          min_count = it.total_count;
          for (i = 0; i < filled; i++) begin
            if (count_mem[i] < min_count) begin
              min_count = count_mem[i];
              min_slot = i;
            end
          end
          res.outcome = OUT_REPLACED;
          res.slot = s[7:0];
        end
      end else begin
        newest = (newest + 1) % cap;
        row_mem[newest] = row;
        count_mem[newest] = it.total_count;
        res.outcome = OUT_REPLACED;
        res.slot = newest[7:0];
      end
    end else begin
      row_mem[filled] = row;
      count_mem[filled] = it.total_count;
      if (filled == 0 || it.total_count < min_count) begin
        min_count = it.total_count;
        min_slot = filled;
      end
      res.outcome = OUT_ADDED;
      res.slot = filled[7:0];
      filled++;
    end
    return res;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode = MODE_ADD;
    it.key_word_0 = {$urandom, $urandom};
    it.key_word_1 = {$urandom, $urandom};
    it.key_word_2 = {$urandom, $urandom};
    it.key_word_3 = {$urandom, $urandom};
    it.key_word_4 = {$urandom, $urandom};
    it.key_word_5 = {$urandom, $urandom};
    it.key_word_6 = {$urandom, $urandom};
    it.key_word_7 = {$urandom, $urandom};
    it.side_to_move = 1'($urandom_range(0, 1));
    it.total_count = pick_count();
    return it;
  endfunction

  function automatic in_item_t directed_item(input logic [1:0] mode, input logic [63:0] pattern,
                                             input logic side, input logic [31:0] count);
    in_item_t it;
    it = '{mode, pattern, pattern, pattern, pattern, pattern, pattern, pattern, pattern,
           side, count};
    return it;
  endfunction

  // Called at a falling edge; returns at a falling edge with no pending assignment.
  task automatic send_item(input in_item_t it);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    due_results.push_back(model_cache_access(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (due_results.size() > 0 || busy !== 1'b0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REPLACE_POLICY) policy_sel = val[0];
    else cap_setting = val;
    @(negedge clk);
  endtask

  task automatic configure_phase(input logic pol, input logic [CFG_W-1:0] cap);
    in_item_t it;
    int       eff;
    int       i;
    it = random_item();
    it.mode = MODE_CLEAR;
    send_item(it);
    drain_results();
    write_register(CFG_REPLACE_POLICY, CFG_W'(pol));
    write_register(CFG_CAPACITY, cap);
    settings_used++;
    steady_sender = ($urandom_range(0, 3) == 0);
    eff = (cap == 0) ? 1 : (cap > MAX_SLOTS) ? MAX_SLOTS : int'(cap);
    pool_size = (2 * eff + 2 > POOL_DEPTH) ? POOL_DEPTH : 2 * eff + 2;
    for (i = 0; i < pool_size; i++) key_pool[i] = random_item();
  endtask

  task automatic prefill_cache(input int n);
    in_item_t it;
    int       i;
    for (i = 0; i < n; i++) begin
      it = random_item();
      key_pool[i % pool_size] = it;
      send_item(it);
    end
  endtask

  // Mostly keys already in the pool, some one-bit variants of them, a few new ones.
  task automatic send_random_items(input int n, input int clear_pct);
    in_item_t it;
    int       j;
    int       k;
    int       r;
    int       pos;
    for (j = 0; j < n; j++) begin
      k = $urandom_range(0, pool_size - 1);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        it = key_pool[k];
      end else if (r < 85) begin
        it = key_pool[k];
        pos = $urandom_range(COUNT_W, COUNT_W + KEY_ROW_W - 1);
        it[pos] = ~it[pos];
        key_pool[$urandom_range(0, pool_size - 1)] = it;
      end else begin
        it = random_item();
        key_pool[k] = it;
      end
      it.total_count = pick_count();
      r = $urandom_range(0, 99);
      if (r < clear_pct) it.mode = MODE_CLEAR;
      else if (r < clear_pct + 3) it.mode = MODE_LOOKUP_ALT;
      else if (r < clear_pct + 38) it.mode = MODE_LOOKUP;
      else it.mode = MODE_ADD;
      send_item(it);
    end
  endtask

  task automatic test_basic_operations();
    send_item(directed_item(MODE_LOOKUP, '0, 1'b0, '0));
    send_item(directed_item(MODE_ADD, '0, 1'b0, '0));
    send_item(directed_item(MODE_ADD, '1, 1'b1, '1));
    send_item(directed_item(MODE_LOOKUP, '1, 1'b1, '0));
    send_item(directed_item(MODE_LOOKUP, '1, 1'b0, '0));
    send_item(directed_item(MODE_LOOKUP_ALT, '0, 1'b0, '1));
    send_item(directed_item(MODE_ADD, '0, 1'b0, 32'd5));
    send_item(directed_item(MODE_CLEAR, '1, 1'b1, '1));
    send_item(directed_item(MODE_LOOKUP, '0, 1'b0, '0));
  endtask

  task automatic test_directed_replacement();
    configure_phase(POLICY_OLDEST, 9'd2);
    send_item(directed_item(MODE_ADD, 64'h0123456789abcdef, 1'b0, 32'd1));
    send_item(directed_item(MODE_ADD, 64'hfedcba9876543210, 1'b1, 32'd2));
    send_item(directed_item(MODE_ADD, 64'h5555aaaa5555aaaa, 1'b0, 32'd3));
    send_item(directed_item(MODE_ADD, 64'h8000000000000001, 1'b1, 32'd4));
    send_item(directed_item(MODE_ADD, 64'h0123456789abcdef, 1'b0, 32'd5));
    configure_phase(POLICY_SMALLEST, 9'd2);
    send_item(directed_item(MODE_ADD, 64'h0123456789abcdef, 1'b0, 32'd100));
    send_item(directed_item(MODE_ADD, 64'hfedcba9876543210, 1'b1, 32'd50));
    send_item(directed_item(MODE_ADD, 64'h5555aaaa5555aaaa, 1'b0, 32'd10));
    send_item(directed_item(MODE_ADD, 64'h8000000000000001, 1'b1, 32'd70));
    send_item(directed_item(MODE_ADD, 64'h0123456789abcdef, 1'b0, 32'd200));
    configure_phase(POLICY_SMALLEST, 9'd0);
    send_item(directed_item(MODE_ADD, 64'h00ff00ff00ff00ff, 1'b0, 32'd9));
    send_item(directed_item(MODE_ADD, 64'hff00ff00ff00ff00, 1'b1, '1));
  endtask

  task automatic test_tiny_capacity();
    configure_phase(POLICY_OLDEST, 9'd1);
    send_random_items(40, 5);
    configure_phase(POLICY_SMALLEST, 9'd0);
    send_random_items(40, 5);
  endtask

  task automatic test_oldest_replacement();
    configure_phase(POLICY_OLDEST, 9'd5);
    send_random_items(100, 6);
    configure_phase(POLICY_OLDEST, 9'd16);
    send_random_items(80, 3);
  endtask

  task automatic test_smallest_replacement();
    configure_phase(POLICY_SMALLEST, 9'd7);
    send_random_items(120, 6);
    configure_phase(POLICY_SMALLEST, 9'd12);
    send_random_items(80, 3);
  endtask

  // The cache stays filled beyond the new capacity and counts as full.
  task automatic test_capacity_shrink();
    configure_phase(POLICY_OLDEST, 9'd16);
    prefill_cache(16);
    drain_results();
    write_register(CFG_CAPACITY, 9'd3);
    send_random_items(30, 0);
    drain_results();
    write_register(CFG_REPLACE_POLICY, CFG_W'(POLICY_SMALLEST));
    send_random_items(30, 0);
    settings_used += 2;
  endtask

  task automatic test_full_capacity();
    configure_phase(POLICY_OLDEST, 9'd256);
    prefill_cache(MAX_SLOTS);
    send_random_items(50, 0);
    configure_phase(POLICY_SMALLEST, 9'd511);
    prefill_cache(MAX_SLOTS);
    send_random_items(50, 0);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: outcome %0d slot %0d",
                                  out_item.outcome, out_item.slot));
      end else begin
        want = due_results.pop_front();
        if (out_item.outcome !== want.outcome)
          report_mismatch($sformatf("result %0d outcome: expected %0d, got %0d",
                                    results_checked, want.outcome, out_item.outcome));
        if (out_item.slot !== want.slot)
          report_mismatch($sformatf("result %0d slot: expected %0d, got %0d",
                                    results_checked, want.slot, out_item.slot));
        if (out_item.outcome <= OUT_CLEARED) outcome_seen[out_item.outcome]++;
        results_checked++;
      end
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Run stopped at the cycle limit");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int        k;
    out_item_t lost;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_operations();
    test_directed_replacement();
    test_tiny_capacity();
    test_oldest_replacement();
    test_smallest_replacement();
    test_capacity_shrink();
    test_full_capacity();

    start <= 1'b0;
    for (k = 0; k < END_WAIT && due_results.size() > 0; k++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (due_results.size() > 0) begin
      lost = due_results.pop_front();
      report_mismatch($sformatf("result never arrived: outcome %0d slot %0d",
                                lost.outcome, lost.slot));
    end

    $display("Sent %0d items under %0d register settings and checked %0d results.",
             items_sent, settings_used, results_checked);
    $display("Outcomes: %0d found, %0d not found, %0d added, %0d replaced, %0d refused, %0d %s",
             outcome_seen[OUT_FOUND], outcome_seen[OUT_NOT_FOUND], outcome_seen[OUT_ADDED],
             outcome_seen[OUT_REPLACED], outcome_seen[OUT_REFUSED], outcome_seen[OUT_CLEARED],
             "cleared.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
